// ===== sv/clutch_duty_map_and_fault_filter_defines.svh =====
// Assertion macros for the clutch duty map and fault filter.
// The including module must provide clk_i and rst_ni in scope.
`ifndef CLUTCH_DUTY_MAP_AND_FAULT_FILTER_DEFINES_SVH
`define CLUTCH_DUTY_MAP_AND_FAULT_FILTER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CDMFF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CDMFF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/cdmff_pkg.sv =====
// Shared types and constants for the clutch duty map and fault filter.
// No dependencies; imported by every module of the block.
`default_nettype none

package cdmff_pkg;

  localparam int MaxFingers = 3;

  localparam logic [2:0] RegTempLow    = 3'd0;
  localparam logic [2:0] RegTempHigh   = 3'd1;
  localparam logic [2:0] RegTripCount  = 3'd2;
  localparam logic [2:0] RegBaseRpm    = 3'd3;
  localparam logic [2:0] RegRpmPerFing = 3'd4;

  localparam logic [2:0] SrcNone  = 3'd0;
  localparam logic [2:0] SrcMotor = 3'd4;

  localparam logic [13:0] PotLow  = 14'd2000;
  localparam logic [13:0] PotHigh = 14'd8000;
  localparam logic [15:0] DutyMax = 16'd37356;

  // Duty = (1024 * (126000 + 27 p) + 4687) / 9375, done as a reciprocal multiply.
  localparam logic [19:0] DutyOffset = 20'd126000;
  localparam logic [19:0] DutySlope  = 20'd27;
  localparam logic [29:0] DutyRound  = 30'd4687;
  localparam logic [29:0] DutyRecip  = 30'd938249923;
  localparam int          DutyShift  = 43;

  localparam logic [16:0] RpmLimit = 17'd65535;

  typedef struct packed {
    logic signed [11:0] low;
    logic signed [11:0] high;
    logic [7:0]         trip;
  } cdmff_temp_cfg_t;

  typedef struct packed {
    logic [2:0] temp_flags;
    logic       motor_flag;
    logic [2:0] source;
  } cdmff_fault_t;

endpackage

`default_nettype wire

// ===== sv/cdmff_duty_map.sv =====
// Maps one potentiometer reading to a clutch duty word.
// Depends on cdmff_pkg for the breakpoints and reciprocal constants.
`default_nettype none

module cdmff_duty_map
  import cdmff_pkg::*;
(
  input  logic [13:0] pot_i,
  output logic [15:0] duty_o
);

  logic [19:0] lin_x;
  logic [29:0] lin_a;
  logic [59:0] lin_prod;

  always_comb begin
    lin_x    = DutyOffset + 20'(pot_i) * DutySlope;
    lin_a    = {lin_x, 10'b0} + DutyRound;
    lin_prod = 60'(lin_a) * 60'(DutyRecip);
    if (pot_i <= PotLow) begin
      duty_o = '0;
    end else if (pot_i >= PotHigh) begin
      duty_o = DutyMax;
    end else begin
      duty_o = lin_prod[DutyShift+15:DutyShift];
    end
  end

endmodule

`default_nettype wire

// ===== sv/cdmff_fault_filter.sv =====
// Temperature window filter with run counters, sticky fault flags and source.
// Depends on cdmff_pkg for the config and fault status structs.
`default_nettype none

module cdmff_fault_filter
  import cdmff_pkg::*;
#(
  parameter int Lanes = 3
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               advance_i,
  input  logic               single_i,
  input  logic signed [11:0] temp_i [MaxFingers],
  input  logic               motor_i,
  input  cdmff_temp_cfg_t    cfg_i,
  output cdmff_fault_t       status_o
);

  cdmff_fault_t stat_q, stat_d;
  logic [7:0]   bad_q [Lanes];
  logic [7:0]   bad_d [Lanes];

  always_comb begin
    logic       blocked;
    logic       bad;
    logic       trip;
    logic [7:0] cnt;
    blocked = 1'b0;
    stat_d  = single_i ? '0 : stat_q;
    bad_d   = bad_q;
    for (int i = 0; i < Lanes; i++) begin
      bad  = (temp_i[i] < $signed(cfg_i.low)) || (temp_i[i] > $signed(cfg_i.high));
      trip = 1'b0;
      cnt  = bad_q[i];
      if (!blocked) begin
        if (single_i) begin
          trip = bad;
        end else if (bad) begin
          if (cnt < cfg_i.trip) begin
            cnt = cnt + 8'd1;
          end
          bad_d[i] = cnt;
          trip     = cnt >= cfg_i.trip;
        end else begin
          bad_d[i] = '0;
        end
        if (trip) begin
          stat_d.temp_flags[i] = 1'b1;
          stat_d.source        = 3'(i + 1);
          blocked              = 1'b1;
        end
      end
    end
    if (!blocked && motor_i) begin
      stat_d.motor_flag = 1'b1;
      stat_d.source     = SrcMotor;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stat_q <= '0;
      for (int i = 0; i < Lanes; i++) begin
        bad_q[i] <= '0;
      end
    end else if (advance_i) begin
      stat_q <= stat_d;
      bad_q  <= bad_d;
    end
  end

  assign status_o = stat_d;

endmodule

`default_nettype wire

// ===== sv/cdmff_rpm_target.sv =====
// Motor speed target from the active finger count, with the changed flag.
// Depends on cdmff_pkg for the finger count and saturation limit.
`default_nettype none

module cdmff_rpm_target
  import cdmff_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  advance_i,
  input  logic                  single_i,
  input  logic [MaxFingers-1:0] active_i,
  input  logic [14:0]           base_rpm_i,
  input  logic [13:0]           rpm_per_finger_i,
  output logic [15:0]           target_o,
  output logic                  changed_o
);

  logic [15:0] last_q;
  logic [1:0]  count;
  logic [15:0] add_rpm;
  logic [16:0] sum_rpm;
  logic [15:0] sat_rpm;

  always_comb begin
    count = '0;
    for (int i = 0; i < MaxFingers; i++) begin
      count = count + 2'(active_i[i]);
    end
    add_rpm = 16'(count) * 16'(rpm_per_finger_i);
    sum_rpm = 17'(base_rpm_i) + 17'(add_rpm);
    sat_rpm = (sum_rpm > RpmLimit) ? RpmLimit[15:0] : sum_rpm[15:0];
    target_o  = single_i ? '0 : sat_rpm;
    changed_o = !single_i && (sat_rpm != last_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else if (advance_i && !single_i) begin
      last_q <= sat_rpm;
    end
  end

endmodule

`default_nettype wire

// ===== sv/clutch_duty_map_and_fault_filter.sv =====
// Clutch duty map and fault filter: top level with config registers and the
// input and result registers. Depends on cdmff_pkg and the three lane modules.
//
// Usage. One input word per control cycle carries the opcode, three pot
// readings, three clutch temperatures and the motor fault pin. The block
// returns one result word for each input word: three duties, the motor
// target with its changed flag, and the sticky fault flags and source.
// Both channels move a word at a clock edge where valid is high and stall is
// low. The input word lands in an input register; the duty map, the
// temperature filter and the target logic work from that register and load
// the result register. Throughput is one word per cycle while the receiver
// does not stall, set by the path through the duty multiplier between the
// two registers. When the receiver stalls, the result holds and the input
// register keeps one more word before the input side is stalled. Reset
// empties both registers, clears the run counters, the sticky flags and the
// last target, and loads the register defaults. Configuration writes take
// effect at once; the user must see that they are made only while idle, as
// the block itself does not enforce this.
`default_nettype none
`include "clutch_duty_map_and_fault_filter_defines.svh"

module clutch_duty_map_and_fault_filter
  import cdmff_pkg::*;
#(
  parameter int FINGERS = 3
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [14:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               opcode_i,
  input  logic [13:0]        pot_a_i,
  input  logic [13:0]        pot_b_i,
  input  logic [13:0]        pot_c_i,
  input  logic signed [11:0] temp_a_i,
  input  logic signed [11:0] temp_b_i,
  input  logic signed [11:0] temp_c_i,
  input  logic               motor_fault_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        duty_a_o,
  output logic [15:0]        duty_b_o,
  output logic [15:0]        duty_c_o,
  output logic [15:0]        target_rpm_o,
  output logic               rpm_changed_o,
  output logic [2:0]         temp_fault_flags_o,
  output logic               motor_fault_flag_o,
  output logic               any_fault_o,
  output logic [2:0]         fault_source_o
);

  localparam int NumFingers = (FINGERS < MaxFingers) ? FINGERS : MaxFingers;

  logic signed [11:0] temp_low_q, temp_high_q;
  logic [7:0]         trip_count_q;
  logic [14:0]        base_rpm_q;
  logic [13:0]        rpm_per_finger_q;

  logic               s1_valid_q;
  logic               s1_op_q;
  logic [13:0]        s1_pot_q [MaxFingers];
  logic signed [11:0] s1_temp_q [MaxFingers];
  logic               s1_motor_q;

  logic               out_valid_q;
  logic [15:0]        duty_q [MaxFingers];
  logic [15:0]        target_q;
  logic               changed_q;
  cdmff_fault_t       status_q;

  logic                  out_ready;
  logic                  advance;
  logic [15:0]           duty_w [MaxFingers];
  logic [MaxFingers-1:0] active_w;
  logic [15:0]           target_w;
  logic                  changed_w;
  cdmff_fault_t          status_w;
  cdmff_temp_cfg_t       temp_cfg;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign advance    = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_low_q       <= 12'sd0;
      temp_high_q      <= 12'sd800;
      trip_count_q     <= 8'd10;
      base_rpm_q       <= 15'd1000;
      rpm_per_finger_q <= 14'd500;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegTempLow:    temp_low_q       <= $signed(cfg_wdata_i[11:0]);
        RegTempHigh:   temp_high_q      <= $signed(cfg_wdata_i[11:0]);
        RegTripCount:  trip_count_q     <= cfg_wdata_i[7:0];
        RegBaseRpm:    base_rpm_q       <= cfg_wdata_i;
        RegRpmPerFing: rpm_per_finger_q <= cfg_wdata_i[13:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_op_q      <= opcode_i;
      s1_pot_q[0]  <= pot_a_i;
      s1_pot_q[1]  <= pot_b_i;
      s1_pot_q[2]  <= pot_c_i;
      s1_temp_q[0] <= temp_a_i;
      s1_temp_q[1] <= temp_b_i;
      s1_temp_q[2] <= temp_c_i;
      s1_motor_q   <= motor_fault_i;
    end
  end

  // An enabled finger's duty is nonzero exactly when its pot reading is above PotLow.
  for (genvar g = 0; g < MaxFingers; g++) begin : g_lane
    if (g < NumFingers) begin : g_on
      cdmff_duty_map u_duty_map (
        .pot_i  (s1_pot_q[g]),
        .duty_o (duty_w[g])
      );
      assign active_w[g] = (s1_pot_q[g] > PotLow);
    end else begin : g_off
      assign duty_w[g]   = '0;
      assign active_w[g] = 1'b0;
    end
  end

  assign temp_cfg = '{low: temp_low_q, high: temp_high_q, trip: trip_count_q};

  cdmff_fault_filter #(
    .Lanes (NumFingers)
  ) u_fault_filter (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .single_i  (s1_op_q),
    .temp_i    (s1_temp_q),
    .motor_i   (s1_motor_q),
    .cfg_i     (temp_cfg),
    .status_o  (status_w)
  );

  cdmff_rpm_target u_rpm_target (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .advance_i        (advance),
    .single_i         (s1_op_q),
    .active_i         (active_w),
    .base_rpm_i       (base_rpm_q),
    .rpm_per_finger_i (rpm_per_finger_q),
    .target_o         (target_w),
    .changed_o        (changed_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      duty_q    <= duty_w;
      target_q  <= target_w;
      changed_q <= changed_w;
      status_q  <= status_w;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign duty_a_o           = duty_q[0];
  assign duty_b_o           = duty_q[1];
  assign duty_c_o           = duty_q[2];
  assign target_rpm_o       = target_q;
  assign rpm_changed_o      = changed_q;
  assign temp_fault_flags_o = status_q.temp_flags;
  assign motor_fault_flag_o = status_q.motor_flag;
  assign any_fault_o        = (status_q.temp_flags != '0) || status_q.motor_flag;
  assign fault_source_o     = status_q.source;

  `CDMFF_ASSERT_NOW(a_source_matches_flags, out_valid_o,
    (fault_source_o == SrcNone) == !any_fault_o, "fault source disagrees with flags")
  `CDMFF_ASSERT_NOW(a_motor_source_flag, out_valid_o && (fault_source_o == SrcMotor),
    motor_fault_flag_o, "motor source without motor flag")
  `CDMFF_ASSERT_NEXT(a_held_word_kept, s1_valid_q && !out_ready,
    s1_valid_q, "input register dropped a held word")

endmodule

`default_nettype wire

// ===== tb/tb_clutch_duty_map_and_fault_filter.sv =====
// Self-checking testbench for clutch_duty_map_and_fault_filter: a directed table, then random
// words under several register settings, checked against a cycle predictor kept in this file.
// Depends on cdmff_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_clutch_duty_map_and_fault_filter;
  import cdmff_pkg::*;

  localparam logic OpFiltered = 1'b0;
  localparam logic OpSingle   = 1'b1;

  localparam logic [2:0] SrcFingerA = 3'd1;
  localparam logic [2:0] SrcFingerB = 3'd2;
  localparam logic [2:0] SrcFingerC = 3'd3;

  localparam logic [13:0] PotFloor = 14'd2000;
  localparam logic [13:0] PotCeil  = 14'd8000;
  localparam logic [15:0] DutyTop  = 16'd37356;

  typedef struct packed {
    logic             op;
    logic [2:0][13:0] pot;
    logic [2:0][11:0] temp;
    logic             mf;
  } cycle_in_t;

  typedef struct packed {
    logic [2:0][15:0] duty;
    logic [15:0]      rpm;
    logic             changed;
    logic [2:0]       tflags;
    logic             mflag;
    logic             any_f;
    logic [2:0]       src;
  } cycle_out_t;

  typedef struct {
    cycle_in_t  in_w;
    logic       typed;
    cycle_out_t want;
  } stim_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_index_i = '0;
  logic [14:0]        cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               opcode_i = 1'b0;
  logic [13:0]        pot_a_i = '0;
  logic [13:0]        pot_b_i = '0;
  logic [13:0]        pot_c_i = '0;
  logic signed [11:0] temp_a_i = '0;
  logic signed [11:0] temp_b_i = '0;
  logic signed [11:0] temp_c_i = '0;
  logic               motor_fault_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [15:0]        duty_a_o;
  logic [15:0]        duty_b_o;
  logic [15:0]        duty_c_o;
  logic [15:0]        target_rpm_o;
  logic               rpm_changed_o;
  logic [2:0]         temp_fault_flags_o;
  logic               motor_fault_flag_o;
  logic               any_fault_o;
  logic [2:0]         fault_source_o;

  logic signed [11:0] lim_lo = 12'sd0;
  logic signed [11:0] lim_hi = 12'sd800;
  logic [7:0]         trip_n = 8'd10;
  logic [14:0]        rpm_base = 15'd1000;
  logic [13:0]        rpm_step = 14'd500;
  logic [7:0]         run_cnt [3] = '{8'd0, 8'd0, 8'd0};
  logic [2:0]         fault_temp = '0;
  logic               fault_motor = 1'b0;
  logic [2:0]         fault_src = SrcNone;
  logic [15:0]        last_rpm = '0;

  cycle_out_t due_outputs [$];
  int         mismatches = 0;
  int         gap_pct = 0;
  int         stall_pct = 0;

  clutch_duty_map_and_fault_filter DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .opcode_i           (opcode_i),
    .pot_a_i            (pot_a_i),
    .pot_b_i            (pot_b_i),
    .pot_c_i            (pot_c_i),
    .temp_a_i           (temp_a_i),
    .temp_b_i           (temp_b_i),
    .temp_c_i           (temp_c_i),
    .motor_fault_i      (motor_fault_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .duty_a_o           (duty_a_o),
    .duty_b_o           (duty_b_o),
    .duty_c_o           (duty_c_o),
    .target_rpm_o       (target_rpm_o),
    .rpm_changed_o      (rpm_changed_o),
    .temp_fault_flags_o (temp_fault_flags_o),
    .motor_fault_flag_o (motor_fault_flag_o),
    .any_fault_o        (any_fault_o),
    .fault_source_o     (fault_source_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic cycle_out_t filter_cycle(cycle_in_t w);
    cycle_out_t      r;
    int              active;
    int              total;
    longint unsigned num;
    logic            bad;
    logic            trip;
    logic            tripped;
    r = '0;
    active = 0;
    tripped = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (w.pot[i] <= PotFloor) begin
        r.duty[i] = '0;
      end else if (w.pot[i] >= PotCeil) begin
        r.duty[i] = DutyTop;
      end else begin
        num = 64'd65536 * (64'd126000 + 64'd27 * w.pot[i]) + 64'd300000;
        r.duty[i] = 16'(num / 64'd600000);
      end
      if (r.duty[i] != 0) active++;
    end
    if (w.op == OpSingle) begin
      fault_temp = '0;
      fault_motor = 1'b0;
      fault_src = SrcNone;
    end
    for (int i = 0; i < 3 && !tripped; i++) begin
      bad = ($signed(w.temp[i]) < lim_lo) || ($signed(w.temp[i]) > lim_hi);
      trip = 1'b0;
      if (w.op == OpSingle) begin
        trip = bad;
      end else if (bad) begin
        if (run_cnt[i] < trip_n) run_cnt[i]++;
        trip = run_cnt[i] >= trip_n;
      end else begin
        run_cnt[i] = '0;
      end
      if (trip) begin
        fault_temp[i] = 1'b1;
        fault_src = 3'(i + 1);
        tripped = 1'b1;
      end
    end
    if (!tripped && w.mf) begin
      fault_motor = 1'b1;
      fault_src = SrcMotor;
    end
    if (w.op == OpFiltered) begin
      total = int'(rpm_base) + active * int'(rpm_step);
      if (total > 65535) total = 65535;
      r.rpm = 16'(total);
      r.changed = r.rpm != last_rpm;
      last_rpm = r.rpm;
    end
    r.tflags = fault_temp;
    r.mflag = fault_motor;
    r.any_f = (fault_temp != 0) || fault_motor;
    r.src = fault_src;
    return r;
  endfunction

  function automatic cycle_in_t mk_item(logic op, int pa, int pb, int pc,
                                        int ta, int tb, int tc, logic mf);
    cycle_in_t w;
    w.op = op;
    w.pot[0] = 14'(pa);
    w.pot[1] = 14'(pb);
    w.pot[2] = 14'(pc);
    w.temp[0] = 12'(ta);
    w.temp[1] = 12'(tb);
    w.temp[2] = 12'(tc);
    w.mf = mf;
    return w;
  endfunction

  function automatic cycle_out_t mk_out(int da, int db, int dc, int rpm, logic chg,
                                        logic [2:0] tf, logic mflag, logic any_f,
                                        logic [2:0] src);
    cycle_out_t r;
    r.duty[0] = 16'(da);
    r.duty[1] = 16'(db);
    r.duty[2] = 16'(dc);
    r.rpm = 16'(rpm);
    r.changed = chg;
    r.tflags = tf;
    r.mflag = mflag;
    r.any_f = any_f;
    r.src = src;
    return r;
  endfunction

  task automatic send_item(input cycle_in_t w, input logic typed, input cycle_out_t want);
    cycle_out_t predicted;
    in_valid_i <= 1'b1;
    opcode_i <= w.op;
    pot_a_i <= w.pot[0];
    pot_b_i <= w.pot[1];
    pot_c_i <= w.pot[2];
    temp_a_i <= w.temp[0];
    temp_b_i <= w.temp[1];
    temp_c_i <= w.temp[2];
    motor_fault_i <= w.mf;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = filter_cycle(w);
    due_outputs.push_back(typed ? want : predicted);
    if ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(15, 1)) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (due_outputs.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [14:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      RegTempLow:    lim_lo = data[11:0];
      RegTempHigh:   lim_hi = data[11:0];
      RegTripCount:  trip_n = data[7:0];
      RegBaseRpm:    rpm_base = data;
      RegRpmPerFing: rpm_step = data[13:0];
      default: ;
    endcase
  endtask

  task automatic write_limits(input int lo, input int hi, input int trip, input int base_v,
                              input int step_v);
    drain_results();
    write_reg(RegTempLow, 15'(lo));
    write_reg(RegTempHigh, 15'(hi));
    write_reg(RegTripCount, 15'(trip));
    write_reg(RegBaseRpm, 15'(base_v));
    write_reg(RegRpmPerFing, 15'(step_v));
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_random(input int n, input int bad_a, input int bad_b, input int bad_c,
                            input int single_pct, input int motor_pct, input int gap,
                            input int stall);
    cycle_in_t w;
    int        bad_pct [3];
    int        marks [7];
    int        lo;
    int        hi;
    int        v;
    bad_pct = '{bad_a, bad_b, bad_c};
    marks = '{0, 2000, 2001, 7999, 8000, 10000, 16383};
    gap_pct = gap;
    stall_pct = stall;
    lo = lim_lo;
    hi = lim_hi;
    repeat (n) begin
      w.op = ($urandom_range(99) < single_pct) ? OpSingle : OpFiltered;
      w.mf = $urandom_range(99) < motor_pct;
      for (int i = 0; i < 3; i++) begin
        case ($urandom_range(4))
          0: w.pot[i] = 14'($urandom_range(2000));
          1: w.pot[i] = 14'($urandom_range(7999, 2001));
          2: w.pot[i] = 14'($urandom_range(16383, 8000));
          3: w.pot[i] = 14'(marks[$urandom_range(6)]);
          default: w.pot[i] = 14'($urandom_range(10000));
        endcase
        if ($urandom_range(99) >= bad_pct[i] && lo <= hi) begin
          case ($urandom_range(3))
            0: v = lo;
            1: v = hi;
            default: v = lo + int'($urandom_range(hi - lo));
          endcase
        end else if (lo > -2048 && (hi >= 2047 || $urandom_range(1) == 0)) begin
          v = $urandom_range(1) ? lo - 1 : -2048 + int'($urandom_range(lo + 2047));
        end else if (hi < 2047) begin
          v = $urandom_range(1) ? hi + 1 : hi + 1 + int'($urandom_range(2046 - hi));
        end else begin
          v = int'($urandom_range(4095));
        end
        w.temp[i] = 12'(v);
      end
      send_item(w, 1'b0, '0);
    end
  endtask

  initial begin : stall_gen
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ($urandom_range(99) < stall_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(15, 1)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    cycle_out_t got;
    cycle_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.duty[0] = duty_a_o;
      got.duty[1] = duty_b_o;
      got.duty[2] = duty_c_o;
      got.rpm = target_rpm_o;
      got.changed = rpm_changed_o;
      got.tflags = temp_fault_flags_o;
      got.mflag = motor_fault_flag_o;
      got.any_f = any_fault_o;
      got.src = fault_source_o;
      if (due_outputs.size() == 0) begin
        if (mismatches < 10) $display("%0t: result word with none expected", $realtime);
        mismatches++;
      end else begin
        want = due_outputs.pop_front();
        if (got !== want) begin
          if (mismatches < 10) begin
            $display("%0t: mismatch, expected duty %0d %0d %0d rpm %0d chg %b tf %b mf %b any %b src %0d",
                     $realtime, want.duty[0], want.duty[1], want.duty[2], want.rpm,
                     want.changed, want.tflags, want.mflag, want.any_f, want.src);
            $display("%0t: mismatch, actual   duty %0d %0d %0d rpm %0d chg %b tf %b mf %b any %b src %0d",
                     $realtime, got.duty[0], got.duty[1], got.duty[2], got.rpm,
                     got.changed, got.tflags, got.mflag, got.any_f, got.src);
          end
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    stim_row_t rows [$];
    rows.push_back('{mk_item(OpFiltered, 0, 0, 0, 250, 250, 250, 1'b0), 1'b1,
                     mk_out(0, 0, 0, 1000, 1'b1, 3'b000, 1'b0, 1'b0, SrcNone)});
    rows.push_back('{mk_item(OpFiltered, 8000, 10000, 16383, 0, 800, 400, 1'b0), 1'b1,
                     mk_out(37356, 37356, 37356, 2500, 1'b1, 3'b000, 1'b0, 1'b0, SrcNone)});
    rows.push_back('{mk_item(OpFiltered, 8000, 10000, 16383, 0, 800, 400, 1'b0), 1'b1,
                     mk_out(37356, 37356, 37356, 2500, 1'b0, 3'b000, 1'b0, 1'b0, SrcNone)});
    rows.push_back('{mk_item(OpFiltered, 2000, 2001, 7999, 801, -1, 2047, 1'b0), 1'b0, '0});
    rows.push_back('{mk_item(OpFiltered, 5000, 1, 12000, -2048, 0, 0, 1'b1), 1'b0, '0});
    rows.push_back('{mk_item(OpFiltered, 0, 0, 0, 900, 900, 900, 1'b0), 1'b0, '0});
    rows.push_back('{mk_item(OpSingle, 0, 0, 0, 250, 250, 250, 1'b0), 1'b1,
                     mk_out(0, 0, 0, 0, 1'b0, 3'b000, 1'b0, 1'b0, SrcNone)});
    rows.push_back('{mk_item(OpSingle, 0, 0, 0, 801, 250, 250, 1'b0), 1'b1,
                     mk_out(0, 0, 0, 0, 1'b0, 3'b001, 1'b0, 1'b1, SrcFingerA)});
    rows.push_back('{mk_item(OpSingle, 8000, 8000, 8000, 250, -1, 250, 1'b1), 1'b1,
                     mk_out(37356, 37356, 37356, 0, 1'b0, 3'b010, 1'b0, 1'b1, SrcFingerB)});
    rows.push_back('{mk_item(OpSingle, 0, 0, 0, 250, 250, 2047, 1'b1), 1'b1,
                     mk_out(0, 0, 0, 0, 1'b0, 3'b100, 1'b0, 1'b1, SrcFingerC)});
    rows.push_back('{mk_item(OpSingle, 0, 0, 0, 250, 250, 250, 1'b1), 1'b1,
                     mk_out(0, 0, 0, 0, 1'b0, 3'b000, 1'b1, 1'b1, SrcMotor)});
    rows.push_back('{mk_item(OpSingle, 0, 0, 0, -2048, 2047, -2048, 1'b1), 1'b1,
                     mk_out(0, 0, 0, 0, 1'b0, 3'b001, 1'b0, 1'b1, SrcFingerA)});
    rows.push_back('{mk_item(OpSingle, 16383, 0, 0, 0, 0, 0, 1'b0), 1'b1,
                     mk_out(37356, 0, 0, 0, 1'b0, 3'b000, 1'b0, 1'b0, SrcNone)});
    // Seven more hot samples on finger one reach the default run length of ten.
    for (int k = 0; k < 7; k++) begin
      rows.push_back('{mk_item(OpFiltered, 1500 * k, 9000 - 1200 * k, 3000 + 700 * k,
                               1000, 100, 700, k[0]), 1'b0, '0});
    end
    rows.push_back('{mk_item(OpFiltered, 3333, 6666, 9999, 0, 0, 0, 1'b0), 1'b0, '0});
    rows.push_back('{mk_item(OpFiltered, 0, 0, 0, 0, 800, 0, 1'b1), 1'b0, '0});

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    gap_pct = 25;
    stall_pct = 8;
    foreach (rows[k]) send_item(rows[k].in_w, rows[k].typed, rows[k].want);

    write_limits(-400, 2000, 3, 1000, 500);
    run_random(200, 30, 30, 30, 10, 5, 20, 8);
    write_limits(-2048, 2047, 255, 0, 0);
    run_random(100, 50, 50, 50, 10, 20, 0, 0);
    write_limits(2047, -2048, 0, 32767, 16383);
    run_random(100, 100, 100, 100, 20, 50, 40, 15);
    write_limits(100, 300, 255, 20000, 10000);
    run_random(300, 0, 2, 100, 2, 10, 10, 5);
    write_limits(0, 800, 1, 1000, 500);
    run_random(200, 20, 20, 20, 15, 10, 30, 15);
    write_limits(-400, 2000, 5, 12345, 321);
    run_random(400, 60, 60, 60, 10, 5, 0, 0);
    drain_results();

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
